>>> sv/motor_feedback_decoder_unit_defines.svh
// Assertion macros for the motor feedback decoder RTL, used by mfd_track.
// Expect signals named clock and reset in the module that uses them.
`ifndef MOTOR_FEEDBACK_DECODER_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/mfd_pkg.sv
// Shared types and constants of the motor feedback decoder.
// No dependencies; used by every module of the block.
package mfd_pkg;

   localparam int MOTORS_DEFAULT          = 8;
   localparam int COUNTS_PER_TURN_DEFAULT = 8192;

   localparam logic [10:0] ID_BASE          = 11'h200;
   localparam logic [7:0]  ENABLE_MASK_RESET = 8'h00;
   localparam logic [15:0] FILTER_ALPHA_RESET = 16'd6554;

   typedef enum logic [0:0] {
      CSR_ENABLE_MASK  = 1'b0,
      CSR_FILTER_ALPHA = 1'b1
   } mfd_csr_type;

   typedef struct packed {
      logic [10:0] frame_id;
      logic [15:0] angle_word;
      logic [15:0] speed_word;
      logic [15:0] current_word;
   } mfd_req_type;

   typedef struct packed {
      logic [3:0]         motor_number;
      logic signed [31:0] position;
      logic signed [15:0] speed_filtered;
      logic signed [15:0] current_value;
   } mfd_rsp_type;

   // decoded frame held between intake and tracker
   typedef struct packed {
      logic [3:0]  motor_number;
      logic [15:0] angle_word;
      logic [15:0] speed_word;
      logic [15:0] current_word;
   } mfd_work_type;

endpackage

>>> sv/mfd_intake.sv
// Input register of the motor feedback decoder: identifier decode and mask filter.
// Depends on mfd_pkg.
module mfd_intake import mfd_pkg::*; #(
   parameter int MOTORS = MOTORS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  mfd_req_type  req_data,
   input  logic [7:0]   enable_mask,
   input  logic         take,
   output logic         work_valid,
   output mfd_work_type work
);

   logic         work_valid_ff, work_valid_in;
   mfd_work_type work_ff, work_in;
   logic [10:0]  offset;
   logic         in_range, hit, load;

   assign offset   = req_data.frame_id - ID_BASE;
   assign in_range = (req_data.frame_id > ID_BASE) &&
                     (req_data.frame_id <= ID_BASE + 11'(MOTORS));
   assign hit      = in_range && enable_mask[3'(offset - 11'd1)];

   // register frees when empty or when its item moves on this cycle
   assign load      = !work_valid_ff || take;
   assign req_stall = !load;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      if (load) begin
         // dropped frames are taken but never enter the pipeline
         work_valid_in         = req_valid && hit;
         work_in.motor_number  = offset[3:0];
         work_in.angle_word    = req_data.angle_word;
         work_in.speed_word    = req_data.speed_word;
         work_in.current_word  = req_data.current_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
      end
      work_ff <= work_in;
   end

   assign work_valid = work_valid_ff;
   assign work       = work_ff;

endmodule

>>> sv/mfd_ema.sv
// Exponential moving average of one speed sample, Q0.16 weight, truncated to zero.
// Depends on mfd_pkg; purely combinational.
module mfd_ema import mfd_pkg::*; (
   input  logic signed [15:0] sample,
   input  logic signed [15:0] last,
   input  logic [15:0]        alpha,
   output logic signed [15:0] filtered
);

   logic signed [16:0] delta;
   logic signed [33:0] prod;
   logic signed [34:0] acc;
   logic signed [18:0] quot;

   // a*x + (1-a)*last == a*(x-last) + last, scaled by 2^16
   assign delta = 17'(sample) - 17'(last);
   assign prod  = $signed({1'b0, alpha}) * delta;
   assign acc   = 35'(prod) + {{3{last[15]}}, last, 16'h0000};

   always_comb begin
      quot = acc[34:16];
      if (acc[34] && (acc[15:0] != 16'h0000)) begin
         quot = quot + 19'sd1;
      end
   end

   assign filtered = quot[15:0];

endmodule

>>> sv/mfd_track.sv
// Per-motor state, position unwrap, speed filter and result register.
// Depends on mfd_pkg, mfd_ema and the assertion macros header.
`include "motor_feedback_decoder_unit_defines.svh"

module mfd_track import mfd_pkg::*; #(
   parameter int MOTORS          = MOTORS_DEFAULT,
   parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         work_valid,
   input  mfd_work_type work,
   output logic         take,
   input  logic [15:0]  filter_alpha,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output mfd_rsp_type  rsp_data
);

   localparam int IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam logic signed [17:0] Counts = 18'(COUNTS_PER_TURN);
   localparam logic signed [17:0] Half   = 18'(COUNTS_PER_TURN / 2);

   logic [15:0] last_angle_ff    [MOTORS];
   logic [31:0] turn_position_ff [MOTORS];
   logic [15:0] last_speed_ff    [MOTORS];
   logic        seen_ff          [MOTORS];

   logic        rsp_valid_ff, rsp_valid_in;
   mfd_rsp_type rsp_data_ff;

   logic [IdxW-1:0]    idx, rsp_idx;
   logic signed [17:0] diff, step;
   logic [31:0]        position_in;
   logic signed [15:0] speed_in;

   assign idx     = IdxW'(work.motor_number - 4'd1);
   assign rsp_idx = IdxW'(rsp_data_ff.motor_number - 4'd1);

   assign take = work_valid && (!rsp_valid_ff || !rsp_stall);

   // unwrap by one revolution
   assign diff = $signed({2'b00, work.angle_word}) - $signed({2'b00, last_angle_ff[idx]});
   always_comb begin
      if (diff < -Half) begin
         step = diff + Counts;
      end else if (diff > Half) begin
         step = diff - Counts;
      end else begin
         step = diff;
      end
   end
   assign position_in = turn_position_ff[idx] + {{14{step[17]}}, step};

   mfd_ema u_ema (
      .sample   (work.speed_word),
      .last     (last_speed_ff[idx]),
      .alpha    (filter_alpha),
      .filtered (speed_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MOTORS; i++) begin
            last_angle_ff[i]    <= '0;
            turn_position_ff[i] <= '0;
            last_speed_ff[i]    <= '0;
            seen_ff[i]          <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            last_angle_ff[idx]    <= work.angle_word;
            turn_position_ff[idx] <= position_in;
            last_speed_ff[idx]    <= speed_in;
            seen_ff[idx]          <= 1'b1;
         end
      end
      if (take) begin
         rsp_data_ff.motor_number   <= work.motor_number;
         rsp_data_ff.position       <= position_in;
         rsp_data_ff.speed_filtered <= speed_in;
         rsp_data_ff.current_value  <= work.current_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MFD_ASSERT_NOW(a_motor_range, rsp_valid_ff, (rsp_data_ff.motor_number != 4'd0) && (rsp_data_ff.motor_number <= 4'(MOTORS)), "result motor number out of range")
   `MFD_ASSERT_NEXT(a_take_gives_result, take, rsp_valid_ff, "taken item produced no result")
   `MFD_ASSERT_NEXT(a_position_saved, take, turn_position_ff[$past(idx)] == rsp_data_ff.position, "reported position not stored")
   `MFD_ASSERT_NOW(a_result_motor_seen, rsp_valid_ff, seen_ff[rsp_idx], "result for a motor never updated")

endmodule

>>> sv/motor_feedback_decoder_unit.sv
// Top level of the motor feedback decoder: configuration registers and pipeline.
// Depends on mfd_pkg, mfd_intake, mfd_track.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  mfd_req_type  (feedback frame)
//   rsp_*        out   rsp_valid/rsp_stall  mfd_rsp_type  (motor update)
//   csr_*        in    csr_valid/csr_ready  csr_index, csr_wdata
//
// Two-stage pipeline: input register with identifier decode, then state update into the result register.
// One item per cycle sustained while rsp_stall stays low; an item passes both registers before rsp_valid.
// Per-motor state lives in flip-flops and is updated in the cycle an item leaves
// the input register, so consecutive frames for one motor need no bubble.
// Reset clears all motor state and loads the configuration defaults; csr_ready is always high.
// Frames for an unknown or disabled motor are taken and yield no result.
module motor_feedback_decoder_unit import mfd_pkg::*; #(
   parameter int MOTORS          = MOTORS_DEFAULT,
   parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mfd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mfd_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  mfd_csr_type csr_index,
   input  logic [15:0] csr_wdata
);

   logic [7:0]   enable_mask_ff;
   logic [15:0]  filter_alpha_ff;
   logic         take, work_valid;
   mfd_work_type work;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= ENABLE_MASK_RESET;
         filter_alpha_ff <= FILTER_ALPHA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE_MASK:  enable_mask_ff  <= csr_wdata[7:0];
            CSR_FILTER_ALPHA: filter_alpha_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mfd_intake #(
      .MOTORS (MOTORS)
   ) u_intake (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .enable_mask (enable_mask_ff),
      .take        (take),
      .work_valid  (work_valid),
      .work        (work)
   );

   mfd_track #(
      .MOTORS          (MOTORS),
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .work_valid   (work_valid),
      .work         (work),
      .take         (take),
      .filter_alpha (filter_alpha_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

>>> tb/sv/tb_motor_feedback_decoder_unit.sv
// Self-checking testbench for motor_feedback_decoder_unit: directed and random feedback frames,
// per-motor position/speed tracking checked against a scoreboard with its own decoder state.
// Depends on mfd_pkg and the motor_feedback_decoder_unit RTL.
module tb_motor_feedback_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mfd_pkg::*;

   localparam int MOTORS         = MOTORS_DEFAULT;
   localparam int COUNTS         = COUNTS_PER_TURN_DEFAULT;
   localparam int ALPHA_ONE      = 65536;
   localparam int HOLD_OFF       = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   // Tracks every motor the way the block should, queues the updates it owes.
   class motor_tracker;
      logic [7:0]  enable_mask;
      logic [15:0] alpha;
      logic [15:0] last_angle [MOTORS];
      logic [31:0] turn_pos [MOTORS];
      logic [15:0] last_speed [MOTORS];
      mfd_rsp_type pending [$];
      int          predicted;
      int          checked;
      int          mismatches;

      function new();
         enable_mask = ENABLE_MASK_RESET;
         alpha       = FILTER_ALPHA_RESET;
         foreach (last_angle[i]) begin
            last_angle[i] = '0;
            turn_pos[i]   = '0;
            last_speed[i] = '0;
         end
         predicted  = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      function void write_reg(mfd_csr_type idx, logic [15:0] value);
         case (idx)
            CSR_ENABLE_MASK:  enable_mask = value[7:0];
            CSR_FILTER_ALPHA: alpha = value;
            default: ;
         endcase
      endfunction

      function void take_frame(mfd_req_type f);
         int          num;
         int          idx;
         int          diff;
         int          spd;
         longint      acc;
         mfd_rsp_type upd;
         num = int'(f.frame_id) - int'(ID_BASE);
         if (num < 1 || num > MOTORS) return;
         if (!enable_mask[num-1]) return;
         idx = num - 1;
         // unwrap by one revolution, position wraps at 32 bits
         diff = int'(f.angle_word) - int'(last_angle[idx]);
         if (diff < -(COUNTS / 2)) diff += COUNTS;
         else if (diff > COUNTS / 2) diff -= COUNTS;
         turn_pos[idx]   = turn_pos[idx] + diff;
         last_angle[idx] = f.angle_word;
         // Q0.16 moving average, division truncates toward zero
         spd = int'($signed(f.speed_word));
         acc = longint'(alpha) * spd
             + longint'(ALPHA_ONE - int'(alpha)) * longint'($signed(last_speed[idx]));
         acc = acc / ALPHA_ONE;
         last_speed[idx] = acc[15:0];
         upd.motor_number   = num[3:0];
         upd.position       = turn_pos[idx];
         upd.speed_filtered = acc[15:0];
         upd.current_value  = f.current_word;
         pending = {pending, upd};
         predicted++;
      endfunction

      function void match_update(mfd_rsp_type got);
         mfd_rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            $error("update for motor %0d with no frame outstanding", got.motor_number);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.motor_number !== want.motor_number) begin
            $error("motor_number expected %0d actual %0d", want.motor_number, got.motor_number);
            mismatches++;
         end
         if (got.position !== want.position) begin
            $error("position expected %0d actual %0d", want.position, got.position);
            mismatches++;
         end
         if (got.speed_filtered !== want.speed_filtered) begin
            $error("speed_filtered expected %0d actual %0d",
                   want.speed_filtered, got.speed_filtered);
            mismatches++;
         end
         if (got.current_value !== want.current_value) begin
            $error("current_value expected %0d actual %0d",
                   want.current_value, got.current_value);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mfd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mfd_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   mfd_csr_type csr_index = CSR_ENABLE_MASK;
   logic [15:0] csr_wdata = '0;

   motor_tracker trk = new();
   bit           idle_on = 1'b1;
   int           quiet_cycles = 0;
   int           frames_sent = 0;
   int           reg_writes = 0;
   logic [15:0]  shaft [MOTORS];
   logic [15:0]  speed_edges [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};

   motor_feedback_decoder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // update sink: check on acceptance, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) trk.match_update(rsp_data);
      rsp_stall <= idle_on && ($urandom_range(99) < 13);
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("motor_feedback_decoder_unit test failed");
      $finish;
   end

   function automatic mfd_req_type make_frame(logic [10:0] id, logic [15:0] ang,
                                              logic [15:0] spd, logic [15:0] cur);
      mfd_req_type f;
      f.frame_id     = id;
      f.angle_word   = ang;
      f.speed_word   = spd;
      f.current_word = cur;
      return f;
   endfunction

   // Mostly plausible rotation of a known motor; the rest is bus noise.
   function automatic mfd_req_type random_frame();
      int          motor;
      int          step;
      int          pick;
      logic [15:0] ang;
      logic [15:0] spd;
      if ($urandom_range(99) >= 80)
         return make_frame(11'($urandom_range(0, 2047)), 16'($urandom), 16'($urandom),
                           16'($urandom));
      motor = $urandom_range(1, MOTORS);
      pick  = $urandom_range(99);
      if (pick < 70) begin
         step = $urandom_range(0, 8000) - 4000;
         ang  = 16'(((int'(shaft[motor-1]) % COUNTS) + step + COUNTS) % COUNTS);
      end else if (pick < 85) begin
         // jumps right around half a turn
         step = $urandom_range(COUNTS / 2 - 3, COUNTS / 2 + 3);
         if ($urandom_range(1)) step = -step;
         ang = 16'(((int'(shaft[motor-1]) % COUNTS) + step + COUNTS) % COUNTS);
      end else begin
         ang = 16'($urandom);
      end
      shaft[motor-1] = ang;
      spd = ($urandom_range(9) == 0) ? speed_edges[$urandom_range(3)] : 16'($urandom);
      return make_frame(ID_BASE + 11'(motor), ang, spd, 16'($urandom));
   endfunction

   task automatic send_frame(mfd_req_type f);
      int gap = 0;
      while (idle_on && $urandom_range(99) < 13) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall !== 1'b0);
      trk.take_frame(f);
      frames_sent++;
   endtask

   // Let every owed update arrive, then let dropped frames clear the pipeline.
   task automatic drain_updates();
      req_valid <= 1'b0;
      while (trk.pending.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic load_config(logic [15:0] mask_word, logic [15:0] alpha);
      drain_updates();
      csr_valid <= 1'b1;
      csr_index <= CSR_ENABLE_MASK;
      csr_wdata <= mask_word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      trk.write_reg(CSR_ENABLE_MASK, mask_word);
      csr_index <= CSR_FILTER_ALPHA;
      csr_wdata <= alpha;
      do @(posedge clock); while (csr_ready !== 1'b1);
      trk.write_reg(CSR_FILTER_ALPHA, alpha);
      csr_valid <= 1'b0;
      reg_writes += 2;
   endtask

   task automatic run_random(int wanted, bit pause_midway);
      int start;
      start = frames_sent;
      while (frames_sent - start < wanted) begin
         send_frame(random_frame());
         if (pause_midway && frames_sent - start == wanted / 2) begin
            drain_updates();
            pause_midway = 1'b0;
         end
      end
   endtask

   initial begin
      foreach (shaft[i]) shaft[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all motors disabled out of reset
      send_frame(make_frame(ID_BASE + 11'd1, 16'h0123, 16'h0456, 16'h0789));
      load_config(16'h00FF, FILTER_ALPHA_RESET);
      // identifiers outside the motor range
      send_frame(make_frame(ID_BASE, 16'h1111, 16'h2222, 16'h3333));
      send_frame(make_frame(ID_BASE + 11'(MOTORS + 1), 16'h1111, 16'h2222, 16'h3333));
      send_frame(make_frame(11'h000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_frame(make_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_frame(make_frame(ID_BASE - 11'd1, 16'h0000, 16'h0000, 16'h0000));
      // first frame, wrap both ways, exactly half a turn, just over half
      send_frame(make_frame(ID_BASE + 11'd1, 16'h0000, 16'h7FFF, 16'h8000));
      send_frame(make_frame(ID_BASE + 11'd1, 16'h1FFF, 16'h8000, 16'h7FFF));
      send_frame(make_frame(ID_BASE + 11'd1, 16'h0000, 16'h7FFF, 16'h0000));
      send_frame(make_frame(ID_BASE + 11'd1, 16'd4096, 16'h0000, 16'h0001));
      send_frame(make_frame(ID_BASE + 11'd1, 16'h0000, 16'hFFFF, 16'hFFFF));
      send_frame(make_frame(ID_BASE + 11'd1, 16'd4097, 16'h1234, 16'h8001));
      // angles beyond one turn
      send_frame(make_frame(ID_BASE + 11'(MOTORS), 16'hFFFF, 16'h8000, 16'h0000));
      send_frame(make_frame(ID_BASE + 11'(MOTORS), 16'h0000, 16'h8000, 16'h7FFF));
      send_frame(make_frame(ID_BASE + 11'(MOTORS), 16'hFFFF, 16'h8000, 16'hFFFF));
      // partial mask, junk above the mask width, alpha of zero holds speed
      load_config(16'h5AA5, 16'h0000);
      for (int m = 1; m <= MOTORS; m++)
         send_frame(make_frame(ID_BASE + 11'(m), 16'($urandom), 16'h7FFF, 16'($urandom)));

      for (int m = 0; m < MOTORS; m++) shaft[m] = trk.last_angle[m];

      load_config(16'h00FF, 16'hFFFF);
      run_random(120, 1'b1);

      idle_on = 1'b0;
      load_config(16'($urandom_range(1, 255)), 16'($urandom));
      run_random(120, 1'b0);

      idle_on = 1'b1;
      load_config(16'h00FF, FILTER_ALPHA_RESET);
      run_random(100, 1'b0);

      load_config(16'($urandom_range(1, 255)), 16'h0001);
      run_random(100, 1'b0);

      drain_updates();
      $display("%0d frames sent, %0d motor updates checked, %0d register writes",
               frames_sent, trk.checked, reg_writes);
      $display("settings covered: alpha 0, 1, default, random and full; masks none, all, partial");
      if (trk.mismatches == 0 && trk.pending.size() == 0)
         $display("motor_feedback_decoder_unit test passed");
      else
         $display("motor_feedback_decoder_unit test failed");
      $finish;
   end

endmodule
